@@ rtl/core/nonpreemptive_priority_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nonpreemptive priority scheduler checker.
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define NPPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define NPPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/npps_pkg.sv @@
// ----------------------------------------------------------------------------
// npps_pkg
// Shared constants, types and helpers of the priority scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One queue node: job fields plus the link to the next node in order.
    typedef struct packed {
        logic [3:0]       id;
        logic [7:0]       prio;
        logic [15:0]      burst;
        logic [31:0]      arrival;
        logic [PTR_W-1:0] next;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [2:0] {
        EV_QUEUED     = 3'd0,
        EV_DROPPED    = 3'd1,
        EV_DISPATCHED = 3'd2,
        EV_BUSY       = 3'd3,
        EV_IDLE       = 3'd4
    } t_event_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LINK,
        S_DISP,
        S_EMIT
    } t_state;

    // Slot allocation requests; set and clear never occur together.
    typedef struct packed {
        logic             set;
        logic [PTR_W-1:0] set_idx;
        logic             clr;
        logic [PTR_W-1:0] clr_idx;
    } t_alloc_ctl;

    // Unsigned add that saturates at all ones.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/npps_if.sv @@
// ----------------------------------------------------------------------------
// npps_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface npps_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [3:0]  job_id;
    logic [7:0]  job_priority;
    logic [15:0] job_burst;

    modport source (output valid, op, job_id, job_priority, job_burst, input ready);
    modport sink   (input valid, op, job_id, job_priority, job_burst, output ready);
endinterface

interface npps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [3:0]  out_job_id;
    logic [31:0] wait_ticks;
    logic [31:0] turnaround_ticks;
    logic [31:0] now_ticks;

    modport source (output valid, event_kind, out_job_id, wait_ticks, turnaround_ticks,
                    now_ticks, input ready);
    modport sink   (input valid, event_kind, out_job_id, wait_ticks, turnaround_ticks,
                    now_ticks, output ready);
endinterface

`default_nettype wire

@@ rtl/core/npps_ram.sv @@
// ----------------------------------------------------------------------------
// npps_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/npps_alloc.sv @@
// ----------------------------------------------------------------------------
// npps_alloc
// Tracks which node slots are in use and offers the lowest free slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npps_alloc import npps_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_alloc_ctl       i_ctl,
    output logic      [PTR_W-1:0] o_free_idx
);

    logic [QUEUE_DEPTH-1:0] r_used;

    // Slot occupancy bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.set) begin
            r_used[i_ctl.set_idx] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_used[i_ctl.clr_idx] <= 1'b0;
        end
    end

    // Lowest unused slot; only consulted when the queue is not full.
    always_comb begin
        o_free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                o_free_idx = PTR_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/nonpreemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Priority ready queue held as a linked list in RAM, with dispatch timing.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item: op 0 enqueues a job stamped with the current
//   time, op 1 is a clock tick that may dispatch the head job. o_out returns
//   exactly one result item per input item, in order.
//   The queue is a list sorted by priority, lower number first and equal
//   priorities in arrival order, kept in one node RAM of QUEUE_DEPTH entries.
//   Steps per item, from acceptance to result ready:
//     dropped arrival, busy or idle tick: straight to S_EMIT;
//     arrival into an empty queue: node written on acceptance, then S_EMIT;
//     arrival into a queue of n jobs: S_WALK, one RAM read per node up to
//     the insertion point, then S_LINK for the link write unless the job
//     becomes the head, then S_EMIT; dispatching tick: S_DISP, then S_EMIT.
//   A new item is taken while an earlier result still waits in the output
//   register. If the receiver stalls, the finished result of the next item
//   waits until the output register frees and no further item is accepted.
//   Reset clears the time, the processor free time, the job count and the
//   output valid flag; RAM contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nonpreemptive_priority_scheduler import npps_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    npps_in_if.sink     i_in,
    npps_out_if.source  o_out
);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [31:0]       r_clock, n_clock;
    logic [31:0]       r_free_at, n_free_at;
    logic [PTR_W-1:0]  r_cur, n_cur;
    logic [PTR_W-1:0]  r_prev, n_prev;
    t_node             r_prev_node, n_prev_node;
    logic              r_prev_valid, n_prev_valid;
    logic [CNT_W-1:0]  r_idx, n_idx;
    t_node             r_new, n_new;
    logic [PTR_W-1:0]  r_slot, n_slot;
    t_event_kind       r_kind, n_kind;
    logic [3:0]        r_oid, n_oid;
    logic [31:0]       r_wait, n_wait;
    logic [31:0]       r_turn, n_turn;
    logic [31:0]       r_now, n_now;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_kind, n_out_kind;
    logic [3:0]        r_out_id, n_out_id;
    logic [31:0]       r_out_wait, n_out_wait;
    logic [31:0]       r_out_turn, n_out_turn;
    logic [31:0]       r_out_now, n_out_now;

    logic              wr_en, rd_en;
    logic [PTR_W-1:0]  wr_addr, rd_addr;
    t_node             wr_node, rd_node;
    logic [NODE_W-1:0] rd_data;
    t_alloc_ctl        alloc_ctl;
    logic [PTR_W-1:0]  free_idx;
    logic              accept;
    logic [31:0]       clock_inc;
    logic [31:0]       wait_calc;

    // Node storage.
    npps_ram #(.WIDTH(NODE_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_node),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Free slot tracking.
    npps_alloc u_alloc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (alloc_ctl),
        .o_free_idx (free_idx)
    );

    assign rd_node   = t_node'(rd_data);
    assign i_in.ready = (r_state == S_IDLE);
    assign accept    = i_in.valid && i_in.ready;
    assign clock_inc = (r_clock == 32'hFFFF_FFFF) ? r_clock : r_clock + 32'd1;
    assign wait_calc = r_now - rd_node.arrival;

    assign o_out.valid            = r_out_valid;
    assign o_out.event_kind       = r_out_kind;
    assign o_out.out_job_id       = r_out_id;
    assign o_out.wait_ticks       = r_out_wait;
    assign o_out.turnaround_ticks = r_out_turn;
    assign o_out.now_ticks        = r_out_now;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_clock     <= '0;
            r_free_at   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clock     <= n_clock;
            r_free_at   <= n_free_at;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_head       <= n_head;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_node  <= n_prev_node;
        r_prev_valid <= n_prev_valid;
        r_idx        <= n_idx;
        r_new        <= n_new;
        r_slot       <= n_slot;
        r_kind       <= n_kind;
        r_oid        <= n_oid;
        r_wait       <= n_wait;
        r_turn       <= n_turn;
        r_now        <= n_now;
        r_out_kind   <= n_out_kind;
        r_out_id     <= n_out_id;
        r_out_wait   <= n_out_wait;
        r_out_turn   <= n_out_turn;
        r_out_now    <= n_out_now;
    end

    // Sequencer: next state, RAM accesses and result formation.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_clock      = r_clock;
        n_free_at    = r_free_at;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_node  = r_prev_node;
        n_prev_valid = r_prev_valid;
        n_idx        = r_idx;
        n_new        = r_new;
        n_slot       = r_slot;
        n_kind       = r_kind;
        n_oid        = r_oid;
        n_wait       = r_wait;
        n_turn       = r_turn;
        n_now        = r_now;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_wait   = r_out_wait;
        n_out_turn   = r_out_turn;
        n_out_now    = r_out_now;
        wr_en        = 1'b0;
        wr_addr      = r_slot;
        wr_node      = r_new;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        alloc_ctl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now   = r_clock;
                    n_new   = '{id: i_in.job_id, prio: i_in.job_priority,
                                burst: i_in.job_burst, arrival: r_clock, next: '0};
                    n_slot  = free_idx;
                    n_oid   = '0;
                    n_wait  = '0;
                    n_turn  = '0;
                    n_state = S_EMIT;
                    if (!i_in.op) begin
                        n_oid = i_in.job_id;
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_kind = EV_DROPPED;
                        end else if (r_count == '0) begin
                            // First job becomes the whole list.
                            wr_en     = 1'b1;
                            wr_addr   = free_idx;
                            wr_node   = n_new;
                            alloc_ctl = '{set: 1'b1, set_idx: free_idx, clr: 1'b0, clr_idx: '0};
                            n_head    = free_idx;
                            n_count   = r_count + 1'b1;
                            n_kind    = EV_QUEUED;
                        end else begin
                            // Walk the list from the head.
                            rd_en        = 1'b1;
                            rd_addr      = r_head;
                            n_cur        = r_head;
                            n_prev_valid = 1'b0;
                            n_idx        = '0;
                            n_kind       = EV_QUEUED;
                            n_state      = S_WALK;
                        end
                    end else begin
                        if (r_clock < r_free_at) begin
                            n_kind  = EV_BUSY;
                            n_clock = clock_inc;
                        end else if (r_count == '0) begin
                            n_kind  = EV_IDLE;
                            n_clock = clock_inc;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_state = S_DISP;
                        end
                    end
                end
            end

            S_WALK: begin
                alloc_ctl = '{set: 1'b1, set_idx: r_slot, clr: 1'b0, clr_idx: '0};
                if (rd_node.prio > r_new.prio) begin
                    // Insert before the current node.
                    wr_en        = 1'b1;
                    wr_node      = r_new;
                    wr_node.next = r_cur;
                    n_count      = r_count + 1'b1;
                    if (r_prev_valid) begin
                        n_state = S_LINK;
                    end else begin
                        n_head  = r_slot;
                        n_state = S_EMIT;
                    end
                end else begin
                    n_prev       = r_cur;
                    n_prev_node  = rd_node;
                    n_prev_valid = 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        // Append after the tail.
                        wr_en   = 1'b1;
                        wr_node = r_new;
                        n_count = r_count + 1'b1;
                        n_state = S_LINK;
                    end else begin
                        alloc_ctl = '0;
                        rd_en     = 1'b1;
                        rd_addr   = rd_node.next;
                        n_cur     = rd_node.next;
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end

            S_LINK: begin
                // Point the predecessor at the new node.
                wr_en        = 1'b1;
                wr_addr      = r_prev;
                wr_node      = r_prev_node;
                wr_node.next = r_slot;
                n_state      = S_EMIT;
            end

            S_DISP: begin
                n_kind    = EV_DISPATCHED;
                n_oid     = rd_node.id;
                n_wait    = wait_calc;
                n_turn    = sat_add32(wait_calc, {16'd0, rd_node.burst});
                n_free_at = sat_add32(r_now, {16'd0, rd_node.burst});
                n_head    = rd_node.next;
                n_count   = r_count - 1'b1;
                n_clock   = clock_inc;
                alloc_ctl = '{set: 1'b0, set_idx: '0, clr: 1'b1, clr_idx: r_head};
                n_state   = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_id    = r_oid;
                    n_out_wait  = r_wait;
                    n_out_turn  = r_turn;
                    n_out_now   = r_now;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/npps_checker.sv @@
// ----------------------------------------------------------------------------
// npps_checker
// Port-level checks of the scheduler result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nonpreemptive_priority_scheduler_assert.svh"

module npps_checker import npps_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_event_kind,
    input wire logic [3:0]  i_out_job_id,
    input wire logic [31:0] i_wait_ticks,
    input wire logic [31:0] i_turnaround_ticks
);

    // No result is offered right after reset.
    `NPPS_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A stalled result keeps its kind.
    `NPPS_ASSERT(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind), "stalled result changed")

    // Only a dispatch reports times.
    `NPPS_ASSERT(a_times_zero, i_out_valid && (i_event_kind != EV_DISPATCHED) |-> (i_wait_ticks == 32'd0) && (i_turnaround_ticks == 32'd0), "times on non-dispatch result")

    // Busy and idle ticks carry no job.
    `NPPS_ASSERT(a_no_job, i_out_valid && ((i_event_kind == EV_BUSY) || (i_event_kind == EV_IDLE)) |-> (i_out_job_id == 4'd0), "job id on busy or idle result")

endmodule

bind nonpreemptive_priority_scheduler npps_checker u_npps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_event_kind       (o_out.event_kind),
    .i_out_job_id       (o_out.out_job_id),
    .i_wait_ticks       (o_out.wait_ticks),
    .i_turnaround_ticks (o_out.turnaround_ticks)
);

`default_nettype wire

@@ sim/npps_sched_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npps_sched_checker
// Watches both channels of the scheduler, predicts each result item from the
// accepted input items and compares the two field by field.
// ----------------------------------------------------------------------------
module npps_sched_checker import npps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    npps_in_if         i_in,
    npps_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct {
        logic [3:0]  id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [31:0] arrival;
    } t_job;

    typedef struct {
        t_event_kind kind;
        logic [3:0]  id;
        logic [31:0] wait_t;
        logic [31:0] turn_t;
        logic [31:0] now_t;
    } t_sched_result;

    logic [31:0]   now_count;
    logic [31:0]   cpu_free_at;
    t_job          ready_q[$];
    t_sched_result expected_results[$];
    int            fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Work out the result of one accepted item and update the model state.
    task automatic schedule_item(input logic op, input logic [3:0] id,
                                 input logic [7:0] prio, input logic [15:0] burst);
        t_sched_result r;
        t_job          j;
        int            pos;
        r = '{EV_IDLE, 4'd0, 32'd0, 32'd0, now_count};
        if (!op) begin
            r.id = id;
            if (ready_q.size() >= QUEUE_DEPTH) begin
                r.kind = EV_DROPPED;
            end else begin
                // The new job goes behind every job of equal or higher urgency.
                pos = ready_q.size();
                while (pos > 0 && ready_q[pos-1].prio > prio) pos--;
                j = '{id, prio, burst, now_count};
                ready_q.insert(pos, j);
                r.kind = EV_QUEUED;
            end
        end else begin
            if (now_count < cpu_free_at) begin
                r.kind = EV_BUSY;
            end else if (ready_q.size() == 0) begin
                r.kind = EV_IDLE;
            end else begin
                j = ready_q.pop_front();
                r.kind   = EV_DISPATCHED;
                r.id     = j.id;
                r.wait_t = now_count - j.arrival;
                r.turn_t = add_sat(r.wait_t, {16'd0, j.burst});
                cpu_free_at = add_sat(now_count, {16'd0, j.burst});
            end
            if (now_count != 32'hFFFF_FFFF) now_count++;
        end
        expected_results.push_back(r);
    endtask

    // Sample both channels at each rising edge.
    always @(posedge i_clk) begin
        t_sched_result e;
        if (!i_rst_n) begin
            now_count   <= 32'd0;
            cpu_free_at <= 32'd0;
            ready_q.delete();
            expected_results.delete();
            fail_count  = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (i_out.event_kind !== e.kind)
                        report_mismatch($sformatf("event_kind %0d, expected %0d",
                                                  i_out.event_kind, e.kind));
                    if (i_out.out_job_id !== e.id)
                        report_mismatch($sformatf("out_job_id %0d, expected %0d",
                                                  i_out.out_job_id, e.id));
                    if (i_out.wait_ticks !== e.wait_t)
                        report_mismatch($sformatf("wait_ticks %0d, expected %0d",
                                                  i_out.wait_ticks, e.wait_t));
                    if (i_out.turnaround_ticks !== e.turn_t)
                        report_mismatch($sformatf("turnaround_ticks %0d, expected %0d",
                                                  i_out.turnaround_ticks, e.turn_t));
                    if (i_out.now_ticks !== e.now_t)
                        report_mismatch($sformatf("now_ticks %0d, expected %0d",
                                                  i_out.now_ticks, e.now_t));
                end
            end
            if (i_in.valid && i_in.ready)
                schedule_item(i_in.op, i_in.job_id, i_in.job_priority, i_in.job_burst);
        end
    end

endmodule

@@ sim/tb_nonpreemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler
// Drives arrivals and ticks into the scheduler with random gaps and output
// stalls; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler;
    import npps_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   hold_output;
    bit   long_hold_req;

    npps_in_if  in_ch ();
    npps_out_if out_ch ();

    nonpreemptive_priority_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    npps_sched_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and hold it until the block accepts it.
    task automatic send_item(input logic op, input logic [3:0] id,
                             input logic [7:0] prio, input logic [15:0] burst);
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.job_id       <= id;
        in_ch.job_priority <= prio;
        in_ch.job_burst    <= burst;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_with_gap(input logic op, input logic [3:0] id,
                                 input logic [7:0] prio, input logic [15:0] burst,
                                 input bit idle_first);
        int g;
        g = idle_first ? gap_len() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        send_item(op, id, prio, burst);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial begin
        int g;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (hold_output || $urandom_range(0, 3) == 0) begin
                g = gap_len();
                out_ch.ready <= 1'b0;
                repeat (g + 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    // Stimulus.
    initial begin
        bit           gaps;
        logic [7:0]   p;
        logic [15:0]  b;
        int           n;
        hold_output        = 1'b0;
        long_hold_req      = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = 1'b0;
        in_ch.job_id       = 4'd0;
        in_ch.job_priority = 8'd0;
        in_ch.job_burst    = 16'd0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty tick, extremes, equal priorities, full queue, busy.
        send_item(1'b1, 4'd0, 8'd0, 16'd0);
        send_item(1'b0, 4'hF, 8'hFF, 16'hFFFF);
        send_item(1'b0, 4'h1, 8'h00, 16'h0000);
        send_item(1'b0, 4'h2, 8'h00, 16'h0002);
        send_item(1'b0, 4'h3, 8'h80, 16'h0001);
        send_item(1'b1, 4'hF, 8'hFF, 16'hFFFF);
        send_item(1'b1, 4'd0, 8'd0, 16'd0);
        send_item(1'b1, 4'd0, 8'd0, 16'd0);
        send_item(1'b1, 4'd0, 8'd0, 16'd0);
        for (int k = 0; k < 14; k++)
            send_item(1'b0, k[3:0], 8'h55, 16'h0);
        send_item(1'b0, 4'hA, 8'h01, 16'h5);
        send_item(1'b1, 4'd0, 8'd0, 16'd0);

        // Flush by ticks so the queue empties.
        for (int k = 0; k < 80; k++) send_item(1'b1, 4'd0, 8'd0, 16'd0);
        wait_drained();

        // Long receiver hold while items keep coming: the block must back up.
        long_hold_req = 1'b1;
        for (int k = 0; k < 30; k++)
            send_item(1'($urandom_range(0, 1)), 4'($urandom), 8'($urandom),
                      16'($urandom_range(0, 3)));
        wait_drained();

        // Random phases: bursts of arrivals then ticks, small bursts mostly.
        n = 0;
        while (n < 1700) begin
            gaps = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(1, 20)) begin
                p = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
                send_with_gap(1'b0, 4'($urandom), p, b, gaps);
                n++;
            end
            repeat ($urandom_range(1, 30)) begin
                send_with_gap(1'b1, 4'($urandom), 8'($urandom), 16'($urandom), gaps);
                n++;
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
